/* design/swal_pkg.sv */
// ----------------------------------------------------------------------------
// swal_pkg
// Shared widths, defaults, register indexes and controller/datapath
// interface types for the sliding window admission limiter.
// ----------------------------------------------------------------------------
package swal_pkg;

    localparam int WINDOW_MAX_DEF = 1024;
    localparam int NUM_TYPES_DEF  = 1024;

    localparam int ITEM_TYPE_W = 10;
    localparam int CFG_W       = 11;
    localparam int CFG_ADDR_W  = 1;
    localparam int TOTAL_W     = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_WINDOW_SIZE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MAX_PER_TYPE = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] MAX_PER_TYPE_RST = 11'd1;

    typedef struct packed {
        logic clear_start;
        logic clear_step;
        logic load_item;
        logic win_rd;
        logic old_cnt_rd;
        logic old_cnt_wr;
        logic new_cnt_rd;
        logic commit;
    } swal_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic win_full;
        logic old_kept;
    } swal_status_t;

endpackage

/* design/swal_ram.sv */
// ----------------------------------------------------------------------------
// swal_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module swal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/swal_ctrl.sv */
// ----------------------------------------------------------------------------
// swal_ctrl
// Sequencer: count table clear pass, window slot read, departing count
// decrement, arriving count read, commit, and output valid tracking.
// ----------------------------------------------------------------------------
module swal_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_start,
    output logic                  out_valid,
    input  logic                  out_ready,
    output swal_pkg::swal_cmd_t    cmd,
    input  swal_pkg::swal_status_t status
);
    import swal_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_WIN_RD = 7'b0000100,
        ST_OLD_RD = 7'b0001000,
        ST_OLD_WR = 7'b0010000,
        ST_NEW_RD = 7'b0100000,
        ST_UPDATE = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pend_reg;
    logic   pend_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = pend_reg ? ST_WIN_RD : ST_IDLE;
                    pend_next  = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (in_start)
                    begin
                        cmd.clear_start = 1'b1;
                        pend_next       = 1'b1;
                        state_next      = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_WIN_RD;
                    end
                end
            end
            ST_WIN_RD:
            begin
                cmd.win_rd = 1'b1;
                state_next = ST_OLD_RD;
            end
            ST_OLD_RD:
            begin
                if (status.win_full && status.old_kept)
                begin
                    cmd.old_cnt_rd = 1'b1;
                    state_next     = ST_OLD_WR;
                end
                else
                begin
                    state_next = ST_NEW_RD;
                end
            end
            ST_OLD_WR:
            begin
                cmd.old_cnt_wr = 1'b1;
                state_next     = ST_NEW_RD;
            end
            ST_NEW_RD:
            begin
                cmd.new_cnt_rd = 1'b1;
                state_next     = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* design/swal_dp.sv */
// ----------------------------------------------------------------------------
// swal_dp
// Datapath: configuration registers, window slot RAM, per-type count RAM,
// slot pointer, fill count, discard total and the result register.
// ----------------------------------------------------------------------------
module swal_dp #(
    parameter int WINDOW_MAX = swal_pkg::WINDOW_MAX_DEF,
    parameter int NUM_TYPES  = swal_pkg::NUM_TYPES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [swal_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [swal_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic [swal_pkg::ITEM_TYPE_W-1:0]  item_type,
    output logic                              discarded,
    output logic [swal_pkg::TOTAL_W-1:0]      discard_total,
    input  swal_pkg::swal_cmd_t               cmd,
    output swal_pkg::swal_status_t            status
);
    import swal_pkg::*;

    localparam int TYPE_W = $clog2(NUM_TYPES);
    localparam int RCP_K  = ITEM_TYPE_W + TYPE_W;
    localparam int PROD_W = ITEM_TYPE_W + RCP_K;
    localparam int MOD_W  = ITEM_TYPE_W + TYPE_W;
    localparam longint RECIP = ((64'(1) << RCP_K) + 64'(NUM_TYPES) - 64'(1)) / 64'(NUM_TYPES);
    localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SEEN_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (SEEN_W > CFG_W) ? SEEN_W : CFG_W;
    localparam int DIF_W  = CMP_W + 1;
    localparam int SLOT_W = TYPE_W + 1;

    logic [CFG_W-1:0]       window_size_reg;
    logic [CFG_W-1:0]       max_per_type_reg;
    logic [ITEM_TYPE_W-1:0] type_raw_reg;
    logic [TYPE_W-1:0]      clr_addr_reg;
    logic [TYPE_W-1:0]      clr_addr_next;
    logic [PTR_W-1:0]       ptr_reg;
    logic [PTR_W-1:0]       ptr_next;
    logic [SEEN_W-1:0]      seen_reg;
    logic [SEEN_W-1:0]      seen_next;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     total_next;
    logic                   disc_out_reg;
    logic [TOTAL_W-1:0]     total_out_reg;

    logic [PROD_W-1:0]      rcp_prod;
    logic [ITEM_TYPE_W-1:0] rcp_quot;
    logic [MOD_W-1:0]       quot_mul;
    logic [MOD_W-1:0]       mod_diff;
    logic [TYPE_W-1:0]      cur_type;
    logic [CMP_W-1:0]       ws_x;
    logic [CMP_W-1:0]       w_eff;
    logic [DIF_W-1:0]       old_sum;
    logic [PTR_W-1:0]       old_addr;

    logic [SLOT_W-1:0]      win_rdata;
    logic [TYPE_W-1:0]      old_type;
    logic                   cnt_we;
    logic [TYPE_W-1:0]      cnt_waddr;
    logic [CFG_W-1:0]       cnt_wdata;
    logic                   cnt_re;
    logic [TYPE_W-1:0]      cnt_raddr;
    logic [CFG_W-1:0]       cnt_rdata;
    logic [CFG_W-1:0]       cnt_dec;
    logic                   keep;

    // item_type modulo NUM_TYPES by reciprocal multiplication
    assign rcp_prod = PROD_W'(type_raw_reg) * PROD_W'(RECIP);
    assign rcp_quot = rcp_prod[RCP_K +: ITEM_TYPE_W];
    assign quot_mul = MOD_W'(rcp_quot) * MOD_W'(NUM_TYPES);
    assign mod_diff = MOD_W'(type_raw_reg) - quot_mul;
    assign cur_type = mod_diff[TYPE_W-1:0];

    always_comb
    begin
        ws_x = CMP_W'(window_size_reg);
        if (window_size_reg == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (ws_x > CMP_W'(WINDOW_MAX))
        begin
            w_eff = CMP_W'(WINDOW_MAX);
        end
        else
        begin
            w_eff = ws_x;
        end
    end

    always_comb
    begin
        old_sum = DIF_W'(ptr_reg) + DIF_W'(WINDOW_MAX) - DIF_W'(w_eff);
        if (old_sum >= DIF_W'(WINDOW_MAX))
        begin
            old_sum = old_sum - DIF_W'(WINDOW_MAX);
        end
        old_addr = old_sum[PTR_W-1:0];
    end

    assign old_type = win_rdata[TYPE_W-1:0];

    assign status.clear_last = (clr_addr_reg == TYPE_W'(NUM_TYPES - 1));
    assign status.win_full   = (CMP_W'(seen_reg) >= w_eff);
    assign status.old_kept   = win_rdata[TYPE_W];

    assign keep    = (cnt_rdata < max_per_type_reg);
    assign cnt_dec = (cnt_rdata == '0) ? cnt_rdata : cnt_rdata - CFG_W'(1);

    always_comb
    begin
        cnt_we = cmd.clear_step | cmd.old_cnt_wr | (cmd.commit & keep);
        if (cmd.clear_step)
        begin
            cnt_waddr = clr_addr_reg;
            cnt_wdata = '0;
        end
        else if (cmd.old_cnt_wr)
        begin
            cnt_waddr = old_type;
            cnt_wdata = cnt_dec;
        end
        else
        begin
            cnt_waddr = cur_type;
            cnt_wdata = cnt_rdata + CFG_W'(1);
        end
        cnt_re    = cmd.old_cnt_rd | cmd.new_cnt_rd;
        cnt_raddr = cmd.old_cnt_rd ? old_type : cur_type;
    end

    swal_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WINDOW_MAX)
    ) u_win_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (ptr_reg),
        .wdata ({keep, cur_type}),
        .re    (cmd.win_rd),
        .raddr (old_addr),
        .rdata (win_rdata)
    );

    swal_ram #(
        .WIDTH (CFG_W),
        .DEPTH (NUM_TYPES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        ptr_next      = ptr_reg;
        seen_next     = seen_reg;
        total_next    = total_reg;
        if (cmd.clear_start)
        begin
            clr_addr_next = '0;
            ptr_next      = '0;
            seen_next     = '0;
            total_next    = '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_next = clr_addr_reg + TYPE_W'(1);
        end
        else if (cmd.commit)
        begin
            ptr_next = (ptr_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr_reg + PTR_W'(1);
            if (seen_reg != SEEN_W'(WINDOW_MAX))
            begin
                seen_next = seen_reg + SEEN_W'(1);
            end
            if (!keep && (total_reg != '1))
            begin
                total_next = total_reg + TOTAL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= WINDOW_SIZE_RST;
            max_per_type_reg <= MAX_PER_TYPE_RST;
            clr_addr_reg     <= '0;
            ptr_reg          <= '0;
            seen_reg         <= '0;
            total_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_IDX_WINDOW_SIZE:  window_size_reg  <= cfg_wdata;
                    CFG_IDX_MAX_PER_TYPE: max_per_type_reg <= cfg_wdata;
                    default:              ;
                endcase
            end
            clr_addr_reg <= clr_addr_next;
            ptr_reg      <= ptr_next;
            seen_reg     <= seen_next;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            type_raw_reg <= item_type;
        end
        if (cmd.commit)
        begin
            disc_out_reg  <= !keep;
            total_out_reg <= total_next;
        end
    end

    assign discarded     = disc_out_reg;
    assign discard_total = total_out_reg;

endmodule

/* design/sliding_window_admission_limiter.sv */
// ----------------------------------------------------------------------------
// sliding_window_admission_limiter
// Keeps or discards each arrival by the number of kept arrivals of its type
// inside a sliding window of recent arrivals; counts discards.
//
// channel  dir  tdata                       tuser
// s_axis   in   [9:0] item_type, pad zero   [0] start_req
// m_axis   out  [31:0] discard_total        [0] discarded
// cfg      in   cfg_addr 0 window_size, 1 max_per_type, cfg_wdata [10:0]
//
// After its transfer an item runs a window slot read, a departing count read
// and decrement when a kept slot leaves a full window, an arriving count read
// and commit, set by the read-modify-write of the count RAM (one port each way).
// Reset and start_req run a count table clear pass over NUM_TYPES entries;
// s_axis_tready is low during it. A new item transfers while a result waits
// on m_axis; a result that is not taken holds the next one in its final cycle.
// ----------------------------------------------------------------------------
module sliding_window_admission_limiter #(
    parameter int WINDOW_MAX = swal_pkg::WINDOW_MAX_DEF,
    parameter int NUM_TYPES  = swal_pkg::NUM_TYPES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [swal_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [9:0] item_type
    input  logic                              s_axis_tuser,  // [0] start_req
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [swal_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [31:0] discard_total
    output logic                              m_axis_tuser,  // [0] discarded
    input  logic                              cfg_we,
    input  logic [swal_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [swal_pkg::CFG_W-1:0]        cfg_wdata
);
    import swal_pkg::*;

    swal_cmd_t    cmd;
    swal_status_t status;

    swal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_start  (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    swal_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .NUM_TYPES  (NUM_TYPES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .item_type     (s_axis_tdata[ITEM_TYPE_W-1:0]),
        .discarded     (m_axis_tuser),
        .discard_total (m_axis_tdata),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

/* tb/admission_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// admission_checker
// Watches the arrival, result and register channels of the sliding window
// admission limiter. It keeps its own copy of the window, the per-type kept
// counts and the limits, works out the keep/discard verdict and discard total
// of every accepted arrival, and compares each result transfer with the
// oldest verdict still due.
// ----------------------------------------------------------------------------
module admission_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [swal_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [9:0] item_type
    input  logic                               s_axis_tuser,   // [0] start_req
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [swal_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [31:0] discard_total
    input  logic                               m_axis_tuser,   // [0] discarded
    input  logic                               cfg_we,
    input  logic [swal_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [swal_pkg::CFG_W-1:0]         cfg_wdata,
    output int                                 errors,
    output int                                 outstanding,
    output int                                 kept_seen,
    output int                                 discards_seen
);

    localparam int SLOTS = swal_pkg::WINDOW_MAX_DEF;
    localparam int TYPES = swal_pkg::NUM_TYPES_DEF;

    typedef struct packed {
        logic                              discarded;
        logic [swal_pkg::TOTAL_W-1:0]      total;
    } verdict_t;

    logic [swal_pkg::ITEM_TYPE_W-1:0]  slot_type [SLOTS];
    bit                                slot_kept [SLOTS];
    int unsigned                       type_count [TYPES];
    int unsigned                       next_slot;
    int unsigned                       arrivals;
    logic [swal_pkg::TOTAL_W-1:0]      discard_run;
    logic [swal_pkg::CFG_W-1:0]        window_reg;
    logic [swal_pkg::CFG_W-1:0]        limit_reg;
    verdict_t                          expected_verdicts [$];

    function automatic void clear_list();
        foreach (type_count[i])
            type_count[i] = 0;
        next_slot   = 0;
        arrivals    = 0;
        discard_run = '0;
    endfunction

    function automatic void admit_arrival(input logic [swal_pkg::ITEM_TYPE_W-1:0] kind,
                                          input bit restart);
        int unsigned span;
        int unsigned tail;
        bit          keep;
        verdict_t    v;
        span = 32'(window_reg);
        if (span < 1)
            span = 1;
        if (span > SLOTS)
            span = SLOTS;
        if (restart)
            clear_list();
        if (arrivals >= span)
        begin
            tail = (next_slot + SLOTS - span) % SLOTS;
            if (slot_kept[tail] && type_count[slot_type[tail]] > 0)
                type_count[slot_type[tail]]--;
        end
        keep = (type_count[kind] + 1) <= limit_reg;
        if (keep)
            type_count[kind]++;
        else if (discard_run != '1)
            discard_run++;
        slot_type[next_slot] = kind;
        slot_kept[next_slot] = keep;
        next_slot = (next_slot + 1) % SLOTS;
        if (arrivals < SLOTS)
            arrivals++;
        v.discarded = !keep;
        v.total     = discard_run;
        expected_verdicts.push_back(v);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t due;
        if (!rst_n)
        begin
            clear_list();
            window_reg = swal_pkg::WINDOW_SIZE_RST;
            limit_reg  = swal_pkg::MAX_PER_TYPE_RST;
            expected_verdicts.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == swal_pkg::CFG_IDX_WINDOW_SIZE)
                    window_reg = cfg_wdata;
                else if (cfg_addr == swal_pkg::CFG_IDX_MAX_PER_TYPE)
                    limit_reg = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
                admit_arrival(s_axis_tdata[swal_pkg::ITEM_TYPE_W-1:0], s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("result transfer with no arrival due: discarded=%0b total=%0d",
                           m_axis_tuser, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    due = expected_verdicts.pop_front();
                    if (m_axis_tuser !== due.discarded)
                    begin
                        $error("discarded: expected %0b, actual %0b",
                               due.discarded, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata !== due.total)
                    begin
                        $error("discard_total: expected %0d, actual %0d",
                               due.total, m_axis_tdata);
                        errors++;
                    end
                end
                if (m_axis_tuser === 1'b1)
                    discards_seen++;
                else
                    kept_seen++;
            end
            outstanding = expected_verdicts.size();
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sliding window admission limiter. A directed
// opening covers the reset limits, type extremes, a zero limit, clamped
// window sizes and a window that shrinks mid-list; random phases then drive
// clustered and scattered types under a range of limits, long enough for the
// window pointer to wrap, with list restarts at the end. Both channels stall
// at random except for one steady phase.
// ----------------------------------------------------------------------------
module tb;

    import swal_pkg::*;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata;   // [9:0] item_type
    logic                       s_axis_tuser;   // [0] start_req
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;   // [31:0] discard_total
    logic                       m_axis_tuser;   // [0] discarded
    logic                       cfg_we;
    logic [CFG_ADDR_W-1:0]      cfg_addr;
    logic [CFG_W-1:0]           cfg_wdata;

    int errors;
    int outstanding;
    int kept_seen;
    int discards_seen;
    int settings_run;
    bit steady;

    int win_plan [10] = '{8, 1, 1024, 16, 2047, 5, 0, 64, 3, 1024};
    int cap_plan [10] = '{2, 1, 1, 3, 0, 1024, 2047, 4, 1, 2};

    sliding_window_admission_limiter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    admission_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .errors        (errors),
        .outstanding   (outstanding),
        .kept_seen     (kept_seen),
        .discards_seen (discards_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d results still due", outstanding);
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 31);

    task automatic push_arrival(input logic [ITEM_TYPE_W-1:0] kind, input bit restart);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - ITEM_TYPE_W){1'b0}}, kind};
        s_axis_tuser  <= restart;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // block is idle once every verdict is back; a settling wait follows
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_limits(input int win, input int cap);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_IDX_WINDOW_SIZE;
        cfg_wdata <= CFG_W'(win);
        @(posedge clk);
        cfg_addr  <= CFG_IDX_MAX_PER_TYPE;
        cfg_wdata <= CFG_W'(cap);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    initial
    begin : stimulus
        int unsigned              base;
        int unsigned              spread;
        int                       count;
        logic [ITEM_TYPE_W-1:0]   kind;
        bit                       restart;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= CFG_IDX_WINDOW_SIZE;
        cfg_wdata     <= '0;
        steady        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // limits out of reset: one kept per type
        push_arrival(10'd0, 1'b0);
        push_arrival(10'd0, 1'b0);

        set_limits(3, 1);
        push_arrival(10'd0, 1'b1);
        push_arrival(10'd0, 1'b0);
        push_arrival(10'd1023, 1'b0);
        push_arrival(10'd1023, 1'b0);
        push_arrival(10'd5, 1'b0);
        push_arrival(10'd0, 1'b0);
        push_arrival(10'd0, 1'b0);

        // zero limit: everything goes
        set_limits(3, 0);
        push_arrival(10'd7, 1'b0);
        push_arrival(10'd7, 1'b0);
        push_arrival(10'd0, 1'b0);

        // window of zero clamps to one, shrinking mid-list
        set_limits(0, 1);
        push_arrival(10'd9, 1'b0);
        push_arrival(10'd9, 1'b0);
        push_arrival(10'd9, 1'b0);

        // oversize window clamps to the table size; the oversize limit is used as it is
        set_limits(2047, 2047);
        push_arrival(10'd512, 1'b0);
        push_arrival(10'd512, 1'b0);
        push_arrival(10'd1023, 1'b0);

        // clustered types force the limit; restarts only late so the pointer wraps
        for (int p = 0; p < 10; p++)
        begin
            set_limits(win_plan[p], cap_plan[p]);
            base   = $urandom_range(0, 1023);
            spread = $urandom_range(1, 6);
            steady = (p == 3);
            count  = (p == 9) ? 140 : 100;
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(0, 99) < 70)
                    kind = ITEM_TYPE_W'(base + $urandom_range(0, spread - 1));
                else
                    kind = ITEM_TYPE_W'($urandom_range(0, 1023));
                restart = (p == 9) && (i >= 115) && ($urandom_range(0, 99) < 8);
                push_arrival(kind, restart);
            end
        end
        steady = 1'b0;
        settle();
        repeat (20) @(posedge clk);

        $display("%0d arrivals checked (%0d kept, %0d discarded) over %0d limit settings,",
                 kept_seen + discards_seen, kept_seen, discards_seen, settings_run);
        $display("including clamped windows, zero and full limits, pointer wrap and restarts");
        if (errors == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
